### sv/smlp_pkg.sv
// smlp_pkg: widths, register indexes, shared structs and the filter factor table
// for the stereo mix low-pass block. No dependencies.
`default_nettype none

package smlp_pkg;

   localparam int SAMPLE_W  = 16;   // FM samples and filtered outputs
   localparam int PSG_W     = 15;   // raw tone sample, offset binary
   localparam int PCT_W     = 7;    // filter_percent register
   localparam int FACTOR_W  = 17;   // blend factors, 0 .. 0x10000
   localparam int ACC_W     = 32;   // 16.16 accumulator
   localparam int MIX_W     = 17;   // tone plus scaled FM
   localparam int PROD_W    = 34;   // full product width before the wrap
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   localparam int PCT_FULL       = 100;
   localparam int PCT_RESET      = 50;
   localparam int UNITY          = 32'h10000;
   localparam int FACTOR_ENTRIES = 2 ** PCT_W;

   localparam logic [SAMPLE_W-1:0] PSG_CENTER = 16'h4000;
   localparam logic [FACTOR_W-1:0] UNITY_F    = FACTOR_W'(UNITY);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FILTER_PERCENT = 2'd0,
      REG_FM_ENABLE      = 2'd1,
      REG_PSG_ENABLE     = 2'd2
   } reg_index_type;

   typedef logic [FACTOR_W-1:0] factor_table_type [FACTOR_ENTRIES];

   // previous-output weight per percentage; values above full scale saturate
   function automatic factor_table_type build_factor_table();
      factor_table_type t;
      for (int i = 0; i < FACTOR_ENTRIES; i++) begin
         t[i] = FACTOR_W'((UNITY * ((i > PCT_FULL) ? PCT_FULL : i)) / PCT_FULL);
      end
      return t;
   endfunction

   localparam factor_table_type FACTOR_TABLE = build_factor_table();

   typedef struct packed {
      logic [FACTOR_W-1:0] factor_a;
      logic [FACTOR_W-1:0] factor_b;
      logic                fm_en;
      logic                psg_en;
   } cfg_type;

   typedef struct packed {
      logic                    active;   // at least one source enabled
      logic signed [MIX_W-1:0] left;
      logic signed [MIX_W-1:0] right;
   } mix_type;

endpackage

`default_nettype wire

### sv/smlp_if.sv
// smlp_if: valid/ready channel interfaces for sample input, filtered output and
// register writes. Depends on smlp_pkg.
`default_nettype none

interface smlp_req_if;
   import smlp_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] fm_left;
   logic signed [SAMPLE_W-1:0] fm_right;
   logic        [PSG_W-1:0]    psg_sample;
   modport source (output valid, fm_left, fm_right, psg_sample, input ready);
   modport sink   (input valid, fm_left, fm_right, psg_sample, output ready);
endinterface

interface smlp_rsp_if;
   import smlp_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface smlp_csr_if;
   import smlp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/smlp_csr.sv
// smlp_csr: configuration registers; turns the percentage into blend factors
// at write time. Depends on smlp_pkg and smlp_if.
`default_nettype none

module smlp_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   smlp_csr_if.sink         csr_bus,
   output smlp_pkg::cfg_type cfg
);
   import smlp_pkg::*;

   logic [FACTOR_W-1:0] factor_a_ff, factor_a_in;
   logic [FACTOR_W-1:0] factor_b_ff, factor_b_in;
   logic                fm_en_ff, fm_en_in;
   logic                psg_en_ff, psg_en_in;
   logic [FACTOR_W-1:0] lookup;

   assign csr_bus.ready = 1'b1;
   assign lookup = FACTOR_TABLE[csr_bus.data[PCT_W-1:0]];

   always_comb begin
      factor_a_in = factor_a_ff;
      factor_b_in = factor_b_ff;
      fm_en_in    = fm_en_ff;
      psg_en_in   = psg_en_ff;
      if (csr_bus.valid) begin
         unique case (reg_index_type'(csr_bus.index))
            REG_FILTER_PERCENT: begin
               factor_a_in = lookup;
               factor_b_in = UNITY_F - lookup;
            end
            REG_FM_ENABLE:  fm_en_in  = csr_bus.data[0];
            REG_PSG_ENABLE: psg_en_in = csr_bus.data[0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_a_ff <= FACTOR_TABLE[PCT_RESET];
         factor_b_ff <= UNITY_F - FACTOR_TABLE[PCT_RESET];
         fm_en_ff    <= 1'b1;
         psg_en_ff   <= 1'b1;
      end else begin
         factor_a_ff <= factor_a_in;
         factor_b_ff <= factor_b_in;
         fm_en_ff    <= fm_en_in;
         psg_en_ff   <= psg_en_in;
      end
   end

   assign cfg = '{factor_a: factor_a_ff, factor_b: factor_b_ff,
                  fm_en: fm_en_ff, psg_en: psg_en_ff};

endmodule

`default_nettype wire

### sv/smlp_mix.sv
// smlp_mix: recenters and halves the tone sample, scales FM by three quarters
// and selects the per-channel mix. Depends on smlp_pkg.
`default_nettype none

module smlp_mix (
   input  wire logic signed [smlp_pkg::SAMPLE_W-1:0] fm_left,
   input  wire logic signed [smlp_pkg::SAMPLE_W-1:0] fm_right,
   input  wire logic        [smlp_pkg::PSG_W-1:0]    psg_sample,
   input  wire smlp_pkg::cfg_type                    cfg,
   output smlp_pkg::mix_type                         mix
);
   import smlp_pkg::*;

   logic signed [SAMPLE_W+1:0] fl_x3, fr_x3;
   logic signed [SAMPLE_W-1:0] fl, fr;
   logic signed [SAMPLE_W-1:0] psg_c;
   logic signed [PSG_W-1:0]    tone;
   logic signed [MIX_W-1:0]    tone_x, fl_x, fr_x;

   // x*3 then floor divide by 4: keep the upper bits of the 18-bit product
   assign fl_x3 = (18'(fm_left) <<< 1) + 18'(fm_left);
   assign fr_x3 = (18'(fm_right) <<< 1) + 18'(fm_right);
   assign fl    = fl_x3[SAMPLE_W+1:2];
   assign fr    = fr_x3[SAMPLE_W+1:2];

   assign psg_c = $signed({1'b0, psg_sample} - PSG_CENTER);
   assign tone  = psg_c[SAMPLE_W-1:1];

   assign tone_x = MIX_W'(tone);
   assign fl_x   = MIX_W'(fl);
   assign fr_x   = MIX_W'(fr);

   always_comb begin
      mix.active = cfg.fm_en | cfg.psg_en;
      if (cfg.fm_en && cfg.psg_en) begin
         mix.left  = tone_x + fl_x;
         mix.right = tone_x + fr_x;
      end else if (cfg.fm_en) begin
         mix.left  = fl_x;
         mix.right = fr_x;
      end else begin
         mix.left  = tone_x;
         mix.right = tone_x;
      end
   end

endmodule

`default_nettype wire

### sv/smlp_filter.sv
// smlp_filter: per-channel 16.16 one-pole accumulators and the output register
// stage. Depends on smlp_pkg.
`default_nettype none

module smlp_filter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire smlp_pkg::mix_type                 mix,
   input  wire smlp_pkg::cfg_type                 cfg,
   input  wire logic                              out_ready,
   output logic                                   out_valid,
   output logic signed [smlp_pkg::SAMPLE_W-1:0]   out_left,
   output logic signed [smlp_pkg::SAMPLE_W-1:0]   out_right,
   output logic                                   advance
);
   import smlp_pkg::*;

   logic [ACC_W-1:0]           acc_l_ff, acc_l_in;
   logic [ACC_W-1:0]           acc_r_ff, acc_r_in;
   logic                       valid_ff, valid_in;
   logic signed [SAMPLE_W-1:0] left_ff, left_in;
   logic signed [SAMPLE_W-1:0] right_ff, right_in;
   logic signed [FACTOR_W:0]   fa_s, fb_s;
   logic signed [PROD_W-1:0]   pa_l, pb_l, pa_r, pb_r;
   logic [ACC_W-1:0]           upd_l, upd_r;

   assign fa_s = $signed({1'b0, cfg.factor_a});
   assign fb_s = $signed({1'b0, cfg.factor_b});

   // previous output (acc >> 16) times factor_a plus mix times factor_b, mod 2^32
   assign pa_l = PROD_W'($signed(acc_l_ff[ACC_W-1:SAMPLE_W])) * PROD_W'(fa_s);
   assign pa_r = PROD_W'($signed(acc_r_ff[ACC_W-1:SAMPLE_W])) * PROD_W'(fa_s);
   assign pb_l = PROD_W'(mix.left) * PROD_W'(fb_s);
   assign pb_r = PROD_W'(mix.right) * PROD_W'(fb_s);
   assign upd_l = pa_l[ACC_W-1:0] + pb_l[ACC_W-1:0];
   assign upd_r = pa_r[ACC_W-1:0] + pb_r[ACC_W-1:0];

   assign advance = !valid_ff || out_ready;

   always_comb begin
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      left_in  = left_ff;
      right_in = right_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = load;
      end
      if (load) begin
         if (mix.active) begin
            acc_l_in = upd_l;
            acc_r_in = upd_r;
            left_in  = $signed(upd_l[ACC_W-1:SAMPLE_W]);
            right_in = $signed(upd_r[ACC_W-1:SAMPLE_W]);
         end else begin
            left_in  = '0;
            right_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_l_ff <= acc_l_in;
         acc_r_ff <= acc_r_in;
         valid_ff <= valid_in;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign out_valid = valid_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;

endmodule

`default_nettype wire

### sv/stereo_mix_lowpass.sv
// stereo_mix_lowpass: an input transfer passes the input register, then the
// accumulator and result register, before the result is offered.
// Throughput one sample pair per cycle while the result is not held off; the
// accumulator update (16x17 and 17x17 multiplies, 32-bit add) is combinational.
// Reset is synchronous, active high: pipeline empties, accumulators clear,
// filter_percent returns to 50 and both sources are enabled.
`default_nettype none

module stereo_mix_lowpass (
   input  wire logic clock,
   input  wire logic reset,
   smlp_req_if.sink  req_bus,
   smlp_rsp_if.source rsp_bus,
   smlp_csr_if.sink  csr_bus
);
   import smlp_pkg::*;

   // input register stage
   logic                       valid_a_ff, valid_a_in;
   logic signed [SAMPLE_W-1:0] fm_left_ff, fm_left_in;
   logic signed [SAMPLE_W-1:0] fm_right_ff, fm_right_in;
   logic        [PSG_W-1:0]    psg_ff, psg_in;

   cfg_type cfg;
   mix_type mix;
   logic    advance;     // result register can take a new item
   logic    move;        // input stage hands its item to the filter
   logic    req_take;

   smlp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   assign move          = valid_a_ff && advance;
   assign req_bus.ready = !valid_a_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_a_in  = valid_a_ff;
      fm_left_in  = fm_left_ff;
      fm_right_in = fm_right_ff;
      psg_in      = psg_ff;
      if (req_bus.ready) begin
         // input stage is empty or draining this cycle: refill from the port
         valid_a_in = req_bus.valid;
      end
      if (req_take) begin
         fm_left_in  = req_bus.fm_left;
         fm_right_in = req_bus.fm_right;
         psg_in      = req_bus.psg_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
      end
      fm_left_ff  <= fm_left_in;
      fm_right_ff <= fm_right_in;
      psg_ff      <= psg_in;
   end

   // recenter the tone, scale FM, pick the mix by the enables
   smlp_mix u_mix (
      .fm_left    (fm_left_ff),
      .fm_right   (fm_right_ff),
      .psg_sample (psg_ff),
      .cfg        (cfg),
      .mix        (mix)
   );

   // accumulate and hold the result until the result transfer
   smlp_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .load      (move),
      .mix       (mix),
      .cfg       (cfg),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_left  (rsp_bus.left_out),
      .out_right (rsp_bus.right_out),
      .advance   (advance)
   );

   // both sources off gives a silent result
   assert property (@(posedge clock) disable iff (reset)
      move && !cfg.fm_en && !cfg.psg_en |=>
         rsp_bus.left_out == '0 && rsp_bus.right_out == '0)
      else $error("muted mix produced a nonzero result");

   // an item leaving the input stage always shows up as a result
   assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_bus.valid)
      else $error("item lost between input and result stage");

   // input only stalls when both stages are full and the result is held off
   assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> valid_a_ff && rsp_bus.valid && !rsp_bus.ready)
      else $error("input stalled without back pressure");

endmodule

`default_nettype wire
